FILE: design/rctc_pkg.sv
// Shared types and constants for the replica checksum table compare block.
// Used by rctc_cell and replica_checksum_table_compare_top; depends on nothing.
package rctc_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int CNT_W     = 9;   // holds a count of up to 511 slots
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 4;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HUMAN_PLAYERS = 2'd1;

  typedef struct packed {
    logic               opcode;
    logic [3:0]         player;
    logic [31:0]        game_time;
    logic [31:0]        turn;
    logic [31:0]        random_word;
    logic signed [31:0] sum_a;
    logic signed [31:0] sum_b;
    logic signed [31:0] sum_c;
    logic signed [31:0] sum_d;
    logic signed [31:0] sum_e;
  } in_t;

  typedef struct packed {
    logic passed;
    logic sync_error;
    logic out_of_sync;
  } out_t;

  typedef struct packed {
    logic [3:0]  player;
    logic [31:0] wtime;
    logic [31:0] turn;
    logic [31:0] rnd;
    logic [31:0] sa;
    logic [31:0] sb;
    logic [31:0] sc;
    logic [31:0] sd;
    logic [31:0] se;
  } rec_t;

  // Token that walks the chain, one cell per cycle.
  typedef struct packed {
    logic             valid;
    logic             pass2;
    logic             bad;
    logic             hit;
    rec_t             mine;
    logic [CNT_W-1:0] same;
    logic [CNT_W-1:0] diff;
  } link_t;

endpackage

FILE: design/rctc_cell.sv
// One table slot: holds a record and compares it against the passing token.
// Depends on rctc_pkg.
module rctc_cell
  import rctc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  in_t   item,
  input  rec_t  mine,
  input  logic  wr_en,
  input  rec_t  wr_rec,
  input  link_t link_i,
  output link_t link_o
);

  rec_t  rec_r;
  link_t link_r;
  link_t link_nxt;
  logic  sums_diff;
  logic  conflict;
  logic  same_rec;

  always_comb begin
    sums_diff = (rec_r.rnd != item.random_word) || (rec_r.sa != item.sum_a) ||
                (rec_r.sb != item.sum_b) || (rec_r.sc != item.sum_c) ||
                (rec_r.sd != item.sum_d) || (rec_r.se != item.sum_e);
    if (rec_r.turn == item.turn) begin
      conflict = (rec_r.wtime != item.game_time) || sums_diff;
    end else if (rec_r.wtime == item.game_time) begin
      conflict = sums_diff;
    end else begin
      conflict = 1'b0;
    end
    same_rec = (rec_r.wtime == mine.wtime) && (rec_r.turn == mine.turn) &&
               (rec_r.rnd == mine.rnd) && (rec_r.sa == mine.sa) &&
               (rec_r.sb == mine.sb) && (rec_r.sc == mine.sc) &&
               (rec_r.sd == mine.sd) && (rec_r.se == mine.se);
  end

  always_comb begin
    link_nxt = link_i;
    if (link_i.valid) begin
      if (item.opcode == OP_ADD) begin
        link_nxt.bad = link_i.bad | conflict;
      end else if (!link_i.pass2) begin
        if (!link_i.hit && rec_r.player == item.player && rec_r.turn == item.turn) begin
          link_nxt.hit  = 1'b1;
          link_nxt.mine = rec_r;
        end
      end else if (rec_r.turn == item.turn && rec_r.player != item.player) begin
        if (same_rec) begin
          link_nxt.same = link_i.same + CNT_W'(1);
        end else begin
          link_nxt.diff = link_i.diff + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r  <= '0;
      link_r <= '0;
    end else begin
      link_r <= link_nxt;
      if (wr_en) begin
        rec_r <= wr_rec;
      end
    end
  end

  assign link_o = link_r;

endmodule

FILE: design/replica_checksum_table_compare_top.sv
// Top level of the replica checksum table compare block: control, cell chain.
// Depends on rctc_pkg and rctc_cell.
//
// The block keeps a circular table of SLOTS sync records, one per cell of a
// chain, all cleared to zero at reset. One word is worked at a time. An add
// word (check_enable set) advances the write pointer, stores the record in
// that cell and sends a token down the chain, one cell per cycle, that
// gathers any conflict. A disabled add stores nothing and reports fail. A
// query word sends the token down twice, first to find the lowest slot holding
// the player's record for the turn, then to count other players' equal and
// differing records against it; the second pass is skipped when no own
// record is found. The next word can be taken in the same cycle that the
// result appears. A finished result sits in an output register, so the next
// word is taken while it waits. Configuration writes are always ready and
// must only be made while the block is idle.
module replica_checksum_table_compare_top
  import rctc_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
)(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int PW = $clog2(SLOTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [PW-1:0] ptr_r, ptr_nxt;
  in_t           item_r;
  rec_t          mine_r;
  out_t          res_r, res_nxt;
  logic          out_valid_r;
  out_t          out_word_r;
  logic          check_enable_r;
  logic [3:0]    human_players_r;

  link_t         links [SLOTS+1];
  link_t         inj;
  link_t         inj_r;
  logic [SLOTS-1:0] wr_vec;
  logic [SLOTS-1:0] tok_vec;
  rec_t          wr_rec;
  logic          accept;
  logic          wr_go;
  logic          load_mine;
  link_t         tail;
  logic [CNT_W:0] tot;
  logic          quorum;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign tail      = links[SLOTS];

  // Advance the write pointer before the store, wrapping at the table end.
  assign ptr_nxt = (ptr_r == PW'(SLOTS - 1)) ? '0 : ptr_r + PW'(1);
  assign wr_go   = accept && in_word.opcode == OP_ADD && check_enable_r;

  always_comb begin
    wr_rec.player = in_word.player;
    wr_rec.wtime  = in_word.game_time;
    wr_rec.turn   = in_word.turn;
    wr_rec.rnd    = in_word.random_word;
    wr_rec.sa     = in_word.sum_a;
    wr_rec.sb     = in_word.sum_b;
    wr_rec.sc     = in_word.sum_c;
    wr_rec.sd     = in_word.sum_d;
    wr_rec.se     = in_word.sum_e;
  end

  always_comb begin
    tot    = {1'b0, tail.same} + {1'b0, tail.diff};
    quorum = {{(CNT_W-3){1'b0}}, human_players_r} <= tot + (CNT_W+1)'(1);
  end

  // Sequencer: launch the token, turn it round for a second query pass,
  // and collect the verdict at the chain end.
  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    inj       = '0;
    load_mine = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_word.opcode == OP_ADD && !check_enable_r) begin
            res_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            inj.valid = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (tail.valid) begin
          res_nxt = '0;
          if (item_r.opcode == OP_ADD) begin
            res_nxt.passed     = !tail.bad;
            res_nxt.sync_error = tail.bad;
            state_nxt          = S_DONE;
          end else if (!tail.pass2) begin
            if (tail.hit) begin
              load_mine = 1'b1;
              inj.valid = 1'b1;
              inj.pass2 = 1'b1;
            end else begin
              state_nxt = S_DONE;
            end
          end else begin
            res_nxt.out_of_sync = quorum && (tail.diff > tail.same);
            state_nxt           = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      ptr_r           <= '0;
      out_valid_r     <= 1'b0;
      check_enable_r  <= 1'b1;
      human_players_r <= '0;
      inj_r           <= '0;
    end else begin
      state_r <= state_nxt;
      // Register the token so the first cell sees the latched word
      // and the freshly stored record.
      inj_r   <= inj;
      if (wr_go) begin
        ptr_r <= ptr_nxt;
      end
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_CHECK_ENABLE:  check_enable_r  <= cfg_data[0];
          CFG_HUMAN_PLAYERS: human_players_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers: hold the item, the found record and the verdict.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_word;
    end
    if (load_mine) begin
      mine_r <= tail.mine;
    end
    res_r <= res_nxt;
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_word_r <= res_r;
    end
  end

  assign links[0] = inj_r;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    assign wr_vec[g]  = wr_go && (ptr_nxt == PW'(g));
    assign tok_vec[g] = links[g+1].valid;
    rctc_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .item   (item_r),
      .mine   (mine_r),
      .wr_en  (wr_vec[g]),
      .wr_rec (wr_rec),
      .link_i (links[g]),
      .link_o (links[g+1])
    );
  end

  // At most one token is ever in the chain.
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one token in the cell chain");

  // No token travels while the block is idle or holding a verdict.
  a_token_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_SCAN) |-> (tok_vec == '0))
    else $error("token in chain outside a scan");

  // An add never reports both pass and sync error.
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_word_r.passed && out_word_r.sync_error))
    else $error("add reports both passed and sync_error");

  // The write pointer moves only on an accepted, enabled add.
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(wr_go) && $past(rst_n) |-> $stable(ptr_r))
    else $error("write pointer moved without a store");

endmodule
